### hw/rtl/tlg_pkg.sv
// package for the toroidal life generation block
// holds the operation codes and the b3/s23 rule constants
// no dependencies
package tlg_pkg;

   localparam int OP_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_STEP = 2'd1,
      OP_READ = 2'd2
   } op_type;

   localparam int COUNT_W = 4;

   localparam logic [COUNT_W-1:0] BORN_COUNT  = 4'd3;
   localparam logic [COUNT_W-1:0] SURVIVE_MIN = 4'd2;
   localparam logic [COUNT_W-1:0] SURVIVE_MAX = 4'd3;

   localparam int REQ_ROW_W = 5;
   localparam int REQ_COL_W = 6;

endpackage

### hw/rtl/tlg_grid_mem.sv
// grid memory: one word of cells per row, synchronous read through an output register
// rows that were never written read as all dead through per-row valid bits
// no package dependency
module tlg_grid_mem #(
   parameter int ROWS = 32,
   parameter int COLS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [$clog2(ROWS)-1:0] rd_addr,
   output logic [COLS-1:0]         rd_data,
   input  logic                    wr_en,
   input  logic [$clog2(ROWS)-1:0] wr_addr,
   input  logic [COLS-1:0]         wr_data
);

   logic [COLS-1:0] grid_mem_ff [ROWS];
   logic [ROWS-1:0] row_valid_ff;
   logic [COLS-1:0] rd_data_ff;
   logic            rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= grid_mem_ff[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### hw/rtl/tlg_row_rule.sv
// next-generation row: applies b3/s23 to every column of one row at once
// columns wrap around; uses tlg_pkg for the rule constants
module tlg_row_rule #(
   parameter int COLS = 64
) (
   input  logic [COLS-1:0] row_above,
   input  logic [COLS-1:0] row_cur,
   input  logic [COLS-1:0] row_below,
   output logic [COLS-1:0] row_next
);

   for (genvar c = 0; c < COLS; c++) begin : g_col
      localparam int LEFT  = (c == 0) ? COLS - 1 : c - 1;
      localparam int RIGHT = (c == COLS - 1) ? 0 : c + 1;

      logic [tlg_pkg::COUNT_W-1:0] count;

      assign count = tlg_pkg::COUNT_W'(row_above[LEFT]) + tlg_pkg::COUNT_W'(row_above[c])
                   + tlg_pkg::COUNT_W'(row_above[RIGHT]) + tlg_pkg::COUNT_W'(row_cur[LEFT])
                   + tlg_pkg::COUNT_W'(row_cur[RIGHT]) + tlg_pkg::COUNT_W'(row_below[LEFT])
                   + tlg_pkg::COUNT_W'(row_below[c]) + tlg_pkg::COUNT_W'(row_below[RIGHT]);

      assign row_next[c] = row_cur[c]
                         ? (count >= tlg_pkg::SURVIVE_MIN && count <= tlg_pkg::SURVIVE_MAX)
                         : (count == tlg_pkg::BORN_COUNT);
   end

endmodule

### hw/rtl/toroidal_life_generation.sv
// top level of the toroidal life generation block
// uses tlg_pkg, tlg_grid_mem and tlg_row_rule
//
// usage:
//   req channel: tuser carries the operation (load, step, read), tdata the cell
//   row, column and value. rsp channel: one item per request, tdata bit 0 the
//   read cell (zero unless a read), tuser bit 0 set when a generation finished.
//   the grid lives in one synchronous memory, one row per word. a step reads
//   the last row, then rows 0 up to the last again, keeping a three-row window
//   and the old row 0 in registers, and writes each new row back in place.
//   a step reads one row per cycle through the single memory read port, and the
//   row rule evaluates all columns at once. an unused code or a cell outside
//   the grid skips the memory and goes straight to the result.
//   one item is worked on at a time; a new item is accepted while the
//   previous result still sits in the output register.
//   reset clears the control state and marks every row dead at once through
//   per-row valid bits; no clearing pass is needed.
//   when the receiver stalls the finished result waits in front of the output
//   register and no further item is accepted.
module toroidal_life_generation #(
   parameter int GRID_ROWS = 32,
   parameter int GRID_COLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cell_row[4:0], cell_col[10:5], cell_in[11]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // cell_out[0]
   output logic [0:0]  rsp_tuser    // generation_done[0]
);

   localparam int ROW_W = $clog2(GRID_ROWS);
   localparam int COL_W = $clog2(GRID_COLS);
   localparam int CNT_W = $clog2(GRID_ROWS + 3);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GRID_ROWS + 2);
   localparam logic [CNT_W-1:0] CNT_READ_END = CNT_W'(GRID_ROWS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_READ,
      S_STEP,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic                 val_ff, val_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [GRID_COLS-1:0] above_ff, above_in;
   logic [GRID_COLS-1:0] cur_ff, cur_in;
   logic [GRID_COLS-1:0] first_ff, first_in;
   logic                 res_cell_ff, res_cell_in;
   logic                 res_done_ff, res_done_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic                 rsp_cell_ff, rsp_cell_in;
   logic                 rsp_done_ff, rsp_done_in;

   logic                 rd_en;
   logic [ROW_W-1:0]     rd_addr;
   logic [GRID_COLS-1:0] rd_data;
   logic                 wr_en;
   logic [ROW_W-1:0]     wr_addr;
   logic [GRID_COLS-1:0] wr_data;

   logic [GRID_COLS-1:0] step_below;
   logic [GRID_COLS-1:0] new_row;
   logic [GRID_COLS-1:0] load_word;

   logic                            accept;
   tlg_pkg::op_type                 req_op;
   logic [tlg_pkg::REQ_ROW_W-1:0]   req_row;
   logic [tlg_pkg::REQ_COL_W-1:0]   req_col;
   logic                            req_val;
   logic                            req_inside;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_op     = tlg_pkg::op_type'(req_tuser);
   assign req_row    = req_tdata[4:0];
   assign req_col    = req_tdata[10:5];
   assign req_val    = req_tdata[11];
   assign req_inside = (32'(req_row) < 32'(GRID_ROWS)) && (32'(req_col) < 32'(GRID_COLS));

   tlg_grid_mem #(
      .ROWS (GRID_ROWS),
      .COLS (GRID_COLS)
   ) u_grid_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // the last new row wraps down onto the saved old row 0
   assign step_below = (cnt_ff == CNT_LAST) ? first_ff : rd_data;

   tlg_row_rule #(
      .COLS (GRID_COLS)
   ) u_row_rule (
      .row_above (above_ff),
      .row_cur   (cur_ff),
      .row_below (step_below),
      .row_next  (new_row)
   );

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      val_in        = val_ff;
      cnt_in        = cnt_ff;
      above_in      = above_ff;
      cur_in        = cur_ff;
      first_in      = first_ff;
      res_cell_in   = res_cell_ff;
      res_done_in   = res_done_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_cell_in   = rsp_cell_ff;
      rsp_done_in   = rsp_done_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = row_ff;
      wr_data       = new_row;
      load_word     = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               row_in      = ROW_W'(req_row);
               col_in      = COL_W'(req_col);
               val_in      = req_val;
               res_cell_in = 1'b0;
               res_done_in = 1'b0;
               state_in    = S_DONE;
               unique case (req_op)
                  tlg_pkg::OP_LOAD: begin
                     if (req_inside) begin
                        rd_en    = 1'b1;
                        rd_addr  = ROW_W'(req_row);
                        state_in = S_LOAD;
                     end
                  end
                  tlg_pkg::OP_READ: begin
                     if (req_inside) begin
                        rd_en    = 1'b1;
                        rd_addr  = ROW_W'(req_row);
                        state_in = S_READ;
                     end
                  end
                  tlg_pkg::OP_STEP: begin
                     // first read fetches the last row, the one above row 0
                     rd_en    = 1'b1;
                     rd_addr  = ROW_W'(GRID_ROWS - 1);
                     cnt_in   = CNT_W'(1);
                     state_in = S_STEP;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_LOAD: begin
            load_word[col_ff] = val_ff;
            wr_en    = 1'b1;
            wr_addr  = row_ff;
            wr_data  = load_word;
            state_in = S_DONE;
         end
         S_READ: begin
            res_cell_in = rd_data[col_ff];
            state_in    = S_DONE;
         end
         S_STEP: begin
            if (cnt_ff == CNT_W'(1)) begin
               above_in = rd_data;
            end else if (cnt_ff == CNT_W'(2)) begin
               cur_in   = rd_data;
               first_in = rd_data;
            end else begin
               // window complete: write back the new row two behind the read
               wr_en    = 1'b1;
               wr_addr  = ROW_W'(cnt_ff - CNT_W'(3));
               wr_data  = new_row;
               above_in = cur_ff;
               cur_in   = step_below;
            end
            if (cnt_ff <= CNT_READ_END) begin
               rd_en   = 1'b1;
               rd_addr = ROW_W'(cnt_ff - CNT_W'(1));
            end
            if (cnt_ff == CNT_LAST) begin
               res_done_in = 1'b1;
               state_in    = S_DONE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_cell_in   = res_cell_ff;
               rsp_done_in   = res_done_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      row_ff      <= row_in;
      col_ff      <= col_in;
      val_ff      <= val_in;
      cnt_ff      <= cnt_in;
      above_ff    <= above_in;
      cur_ff      <= cur_in;
      first_ff    <= first_in;
      res_cell_ff <= res_cell_in;
      res_done_ff <= res_done_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_cell_ff};
   assign rsp_tuser  = rsp_done_ff;

`ifndef SYNTH
   // a result is either a read answer or a step acknowledgment, never both
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !(rsp_cell_ff && rsp_done_ff))
      else $error("result marks both a live cell and a finished generation");

   // the grid is only written while an item is being worked on
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !wr_en)
      else $error("grid written outside a load or step");

   // the step sequencer stays within its read and write-back window
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (cnt_ff >= CNT_W'(1) && cnt_ff <= CNT_LAST))
      else $error("step row counter out of range");

   // a finished item with a free output register shows up on the next cycle
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_tvalid_ff || rsp_tready)) |=> rsp_tvalid_ff)
      else $error("finished result not presented");
`endif

endmodule

### tb/toroidal_life_generation_test.sv
// testbench for the toroidal life generation block: loads, reads, generation steps and unused
// codes, checked against a shadow copy of the grid that applies rule b3/s23 with wraparound
// depends on tlg_pkg and toroidal_life_generation
module toroidal_life_generation_test;

   localparam int GRID_ROWS = 32;
   localparam int GRID_COLS = 64;
   localparam int ITEM_TARGET = 1450;
   localparam int TAIL_CYCLES = GRID_ROWS + 12;
   localparam int RUN_LIMIT = 20_000_000;
   localparam logic [tlg_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic cell_out;
      logic generation_done;
   } life_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;

   // shadow grid, bit c of word r is the cell at row r, column c
   logic [GRID_COLS-1:0] board [GRID_ROWS];
   life_answer_type answer_q [$];
   life_answer_type got_answer;

   int mismatch_count = 0;
   int answers_checked = 0;
   int items_played = 0;
   int loads_done = 0;
   int steps_done = 0;
   int reads_done = 0;
   int unused_done = 0;
   int input_stall_cycles = 0;
   int rsp_hold_cycles = 0;
   bit sender_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   toroidal_life_generation #(
      .GRID_ROWS(GRID_ROWS),
      .GRID_COLS(GRID_COLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int gap_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      else if (pick < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   function automatic int cell_at(int row, int col);
      return int'(board[(row + GRID_ROWS) % GRID_ROWS][(col + GRID_COLS) % GRID_COLS]);
   endfunction

   task automatic advance_generation();
      logic [GRID_COLS-1:0] fresh [GRID_ROWS];
      int n;
      logic alive;
      for (int r = 0; r < GRID_ROWS; r++) begin
         for (int c = 0; c < GRID_COLS; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++)
               for (int dc = -1; dc <= 1; dc++)
                  if (dr != 0 || dc != 0) n += cell_at(r + dr, c + dc);
            alive = board[r][c];
            fresh[r][c] = alive ? (n >= tlg_pkg::SURVIVE_MIN && n <= tlg_pkg::SURVIVE_MAX)
                                : (n == tlg_pkg::BORN_COUNT);
         end
      end
      board = fresh;
   endtask

   // applies one accepted item to the shadow grid and queues the answer it should give
   task automatic play_item(logic [1:0] op, logic [4:0] row, logic [5:0] col, logic val);
      life_answer_type ans;
      bit in_grid;
      ans = '0;
      in_grid = (row < GRID_ROWS) && (col < GRID_COLS);
      case (op)
         tlg_pkg::OP_LOAD: begin
            if (in_grid) board[row][col] = val;
            loads_done++;
         end
         tlg_pkg::OP_STEP: begin
            advance_generation();
            ans.generation_done = 1'b1;
            steps_done++;
         end
         tlg_pkg::OP_READ: begin
            if (in_grid) ans.cell_out = board[row][col];
            reads_done++;
         end
         default: unused_done++;
      endcase
      if (op != OP_UNUSED) items_played++;
      answer_q.push_back(ans);
   endtask

   // called at a rising edge; returns at the edge where the item was taken, or after the idle gap that follows it
   task automatic send_item(logic [1:0] op, int row, int col, int val);
      logic [4:0] r5;
      logic [5:0] c6;
      logic v1;
      int gap;
      r5 = 5'(row);
      c6 = 6'(col);
      v1 = 1'(val);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'b0, v1, c6, r5};
      do @(posedge clock); while (!req_tready);
      play_item(op, r5, c6, v1);
      gap = sender_idle_on ? gap_cycles() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // receiver: random stalls, plus a long hold-off when a test asks for one
   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles = rsp_hold_cycles - 1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (rsp_idle_on && $urandom_range(0, 99) < 30) begin
            stall_left = gap_cycles();
            rsp_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_tready) input_stall_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               report_mismatch("result item with nothing outstanding", 1, 0);
            end else begin
               got_answer = answer_q.pop_front();
               answers_checked++;
               if (rsp_tdata[0] !== got_answer.cell_out)
                  report_mismatch("cell_out", int'(rsp_tdata[0]), int'(got_answer.cell_out));
               if (rsp_tuser[0] !== got_answer.generation_done)
                  report_mismatch("generation_done", int'(rsp_tuser[0]),
                                  int'(got_answer.generation_done));
            end
         end
      end
   end

   task automatic test_load_read_extremes();
      send_item(tlg_pkg::OP_READ, 0, 0, 0);
      send_item(tlg_pkg::OP_LOAD, 0, 0, 1);
      send_item(tlg_pkg::OP_LOAD, 31, 63, 1);
      send_item(tlg_pkg::OP_READ, 31, 63, 0);
      send_item(tlg_pkg::OP_READ, 0, 0, 1);
      send_item(tlg_pkg::OP_READ, 31, 0, 0);
      send_item(tlg_pkg::OP_LOAD, 31, 63, 0);
      send_item(tlg_pkg::OP_READ, 31, 63, 1);
      send_item(tlg_pkg::OP_LOAD, 0, 0, 0);
   endtask

   // unused code must leave the grid alone and answer zeros
   task automatic test_unused_code();
      send_item(OP_UNUSED, 31, 63, 1);
      send_item(OP_UNUSED, 0, 0, 0);
      send_item(tlg_pkg::OP_READ, 31, 63, 0);
   endtask

   // blinker straddling the column wrap flips onto the row wrap and back
   task automatic test_wrap_blinker();
      send_item(tlg_pkg::OP_LOAD, 0, 63, 1);
      send_item(tlg_pkg::OP_LOAD, 0, 0, 1);
      send_item(tlg_pkg::OP_LOAD, 0, 1, 1);
      send_item(tlg_pkg::OP_STEP, 0, 0, 0);
      send_item(tlg_pkg::OP_READ, 31, 0, 0);
      send_item(tlg_pkg::OP_READ, 1, 0, 0);
      send_item(tlg_pkg::OP_READ, 0, 63, 0);
      send_item(tlg_pkg::OP_STEP, 31, 63, 1);
      send_item(tlg_pkg::OP_READ, 0, 63, 0);
      send_item(tlg_pkg::OP_READ, 31, 0, 0);
   endtask

   task automatic test_input_backpressure();
      sender_idle_on = 1'b0;
      rsp_hold_cycles = 200;
      repeat (12)
         send_item(2'($urandom_range(0, 2)), $urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 1));
      sender_idle_on = 1'b1;
   endtask

   task automatic read_around(int r0, int c0, int h, int w, int count);
      repeat (count)
         send_item(tlg_pkg::OP_READ, (r0 - 2 + $urandom_range(0, h + 3) + GRID_ROWS) % GRID_ROWS,
                   (c0 - 2 + $urandom_range(0, w + 3) + GRID_COLS) % GRID_COLS,
                   $urandom_range(0, 1));
   endtask

   task automatic random_soup();
      int r0, c0, h, w;
      r0 = $urandom_range(0, 31);
      c0 = $urandom_range(0, 63);
      h = $urandom_range(3, 8);
      w = $urandom_range(3, 8);
      repeat ($urandom_range(6, 20))
         send_item(tlg_pkg::OP_LOAD, (r0 + $urandom_range(0, h - 1)) % GRID_ROWS,
                   (c0 + $urandom_range(0, w - 1)) % GRID_COLS, $urandom_range(0, 99) < 70);
      repeat ($urandom_range(1, 4)) begin
         send_item(tlg_pkg::OP_STEP, $urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 1));
         read_around(r0, c0, h, w, $urandom_range(3, 8));
      end
   endtask

   task automatic random_glider();
      int r0, c0;
      r0 = $urandom_range(0, 31);
      c0 = $urandom_range(0, 63);
      for (int r = 0; r < 5; r++)
         for (int c = 0; c < 5; c++)
            send_item(tlg_pkg::OP_LOAD, (r0 + r) % GRID_ROWS, (c0 + c) % GRID_COLS,
                      (r == 1 && c == 2) || (r == 2 && c == 3) || (r == 3 && c >= 1 && c <= 3));
      repeat ($urandom_range(4, 8)) begin
         send_item(tlg_pkg::OP_STEP, 0, 0, 0);
         read_around(r0, c0, 5, 5, $urandom_range(2, 5));
      end
   endtask

   task automatic random_noise();
      repeat (10)
         send_item(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 1));
   endtask

   task automatic test_random_play();
      int pick;
      while (items_played < ITEM_TARGET) begin
         sender_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 65) random_soup();
         else if (pick < 85) random_glider();
         else random_noise();
      end
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      for (int r = 0; r < GRID_ROWS; r++) board[r] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_load_read_extremes();
      test_unused_code();
      test_wrap_blinker();
      test_input_backpressure();
      test_random_play();
      req_tvalid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("played %0d loads, %0d generation steps, %0d reads and %0d unused codes",
               loads_done, steps_done, reads_done, unused_done);
      $display("%0d results checked; input held back for %0d cycles",
               answers_checked, input_stall_cycles);
      if (mismatch_count == 0) begin
         $display("toroidal_life_generation_test passed");
      end else begin
         $display("toroidal_life_generation_test failed");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("timeout with %0d results outstanding", answer_q.size());
      $display("toroidal_life_generation_test failed");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/tlg_pkg.sv
hw/rtl/tlg_grid_mem.sv
hw/rtl/tlg_row_rule.sv
hw/rtl/toroidal_life_generation.sv
tb/toroidal_life_generation_test.sv
